FILE: src/fixed_point_natural_log_defines.svh
// Assertion helpers for the asserting file, fixed_point_natural_log.sv.
`ifndef FIXED_POINT_NATURAL_LOG_DEFINES_SVH
`define FIXED_POINT_NATURAL_LOG_DEFINES_SVH

// Check that a property holds on every rising clock edge outside reset.
`define FPL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check a property with no reset qualifier.
`define FPL_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

FILE: src/fpl_pkg.sv
`timescale 1ns / 1ps
package fpl_pkg;

  localparam logic [31:0] Ln2U527    = 32'd93032640;
  localparam logic [31:0] CubicCoef  = 32'd178958404;
  localparam logic [19:0] BiasS1615  = 20'd393216;

  function automatic logic [31:0] ln_tab(input logic [6:0] k);
    logic [31:0] r;
    case (k)
      7'd0: r = 32'd1610612736;  7'd1: r = 32'd1612693673;
      7'd2: r = 32'd1614742838;  7'd3: r = 32'd1616761188;
      7'd4: r = 32'd1618749635;  7'd5: r = 32'd1620709053;
      7'd6: r = 32'd1622640276;  7'd7: r = 32'd1624544106;
      7'd8: r = 32'd1626421307;  7'd9: r = 32'd1628272616;
      7'd10: r = 32'd1630098736; 7'd11: r = 32'd1631900343;
      7'd12: r = 32'd1633678087; 7'd13: r = 32'd1635432592;
      7'd14: r = 32'd1637164458; 7'd15: r = 32'd1638874261;
      7'd16: r = 32'd1640562556; 7'd17: r = 32'd1642229879;
      7'd18: r = 32'd1643876743; 7'd19: r = 32'd1645503644;
      7'd20: r = 32'd1647111061; 7'd21: r = 32'd1648699455;
      7'd22: r = 32'd1650269271; 7'd23: r = 32'd1651820939;
      7'd24: r = 32'd1653354872; 7'd25: r = 32'd1654871473;
      7'd26: r = 32'd1656371128; 7'd27: r = 32'd1657854212;
      7'd28: r = 32'd1659321087; 7'd29: r = 32'd1660772103;
      7'd30: r = 32'd1662207601; 7'd31: r = 32'd1663627908;
      7'd32: r = 32'd1665033342; 7'd33: r = 32'd1666424211;
      7'd34: r = 32'd1667800815; 7'd35: r = 32'd1669163444;
      7'd36: r = 32'd1670512377; 7'd37: r = 32'd1671847888;
      7'd38: r = 32'd1673170241; 7'd39: r = 32'd1674479692;
      7'd40: r = 32'd1675776492; 7'd41: r = 32'd1677060882;
      7'd42: r = 32'd1678333097; 7'd43: r = 32'd1679593367;
      7'd44: r = 32'd1680841913; 7'd45: r = 32'd1682078952;
      7'd46: r = 32'd1683304693; 7'd47: r = 32'd1684519341;
      7'd48: r = 32'd1685723096; 7'd49: r = 32'd1686916150;
      7'd50: r = 32'd1688098693; 7'd51: r = 32'd1689270907;
      7'd52: r = 32'd1690432973; 7'd53: r = 32'd1691585063;
      7'd54: r = 32'd1692727349; 7'd55: r = 32'd1693859995;
      7'd56: r = 32'd1694983162; 7'd57: r = 32'd1696097009;
      7'd58: r = 32'd1697201687; 7'd59: r = 32'd1698297348;
      7'd60: r = 32'd1699384138; 7'd61: r = 32'd1700462197;
      7'd62: r = 32'd1701531667; 7'd63: r = 32'd1702592682;
      default: r = 32'd1703645376;
    endcase
    return r;
  endfunction

  // Magnitude of the reciprocal correction (entries are >= 0; the correction itself is <= 0).
  function automatic logic [15:0] recip_mag(input logic [6:0] k);
    logic [15:0] r;
    case (k)
      7'd0: r = 16'd0;      7'd1: r = 16'd1008;   7'd2: r = 16'd1986;
      7'd3: r = 16'd2934;   7'd4: r = 16'd3855;   7'd5: r = 16'd4749;
      7'd6: r = 16'd5617;   7'd7: r = 16'd6461;   7'd8: r = 16'd7282;
      7'd9: r = 16'd8080;   7'd10: r = 16'd8856;  7'd11: r = 16'd9612;
      7'd12: r = 16'd10348; 7'd13: r = 16'd11065; 7'd14: r = 16'd11763;
      7'd15: r = 16'd12444; 7'd16: r = 16'd13107; 7'd17: r = 16'd13754;
      7'd18: r = 16'd14386; 7'd19: r = 16'd15002; 7'd20: r = 16'd15604;
      7'd21: r = 16'd16191; 7'd22: r = 16'd16765; 7'd23: r = 16'd17326;
      7'd24: r = 16'd17873; 7'd25: r = 16'd18409; 7'd26: r = 16'd18933;
      7'd27: r = 16'd19445; 7'd28: r = 16'd19946; 7'd29: r = 16'd20436;
      7'd30: r = 16'd20916; 7'd31: r = 16'd21385; 7'd32: r = 16'd21845;
      7'd33: r = 16'd22296; 7'd34: r = 16'd22737; 7'd35: r = 16'd23169;
      7'd36: r = 16'd23593; 7'd37: r = 16'd24008; 7'd38: r = 16'd24415;
      7'd39: r = 16'd24815; 7'd40: r = 16'd25206; 7'd41: r = 16'd25590;
      7'd42: r = 16'd25967; 7'd43: r = 16'd26337; 7'd44: r = 16'd26700;
      7'd45: r = 16'd27056; 7'd46: r = 16'd27406; 7'd47: r = 16'd27749;
      7'd48: r = 16'd28087; 7'd49: r = 16'd28418; 7'd50: r = 16'd28744;
      7'd51: r = 16'd29064; 7'd52: r = 16'd29378; 7'd53: r = 16'd29687;
      7'd54: r = 16'd29991; 7'd55: r = 16'd30290; 7'd56: r = 16'd30583;
      7'd57: r = 16'd30872; 7'd58: r = 16'd31156; 7'd59: r = 16'd31436;
      7'd60: r = 16'd31711; 7'd61: r = 16'd31982; 7'd62: r = 16'd32248;
      7'd63: r = 16'd32510; default: r = 16'd32768;
    endcase
    return r;
  endfunction

  // Side data carried down the pipe alongside the arithmetic.
  typedef struct packed {
    logic        inv;
    logic [4:0]  lz;
    logic [6:0]  k;
  } side_t;

endpackage

FILE: src/fpl_norm.sv
`timescale 1ns / 1ps
// Leading-zero count, normalize, breakpoint index, signed remainder and invalid flag.
module fpl_norm (
  input  logic [31:0]         operand_i,
  output fpl_pkg::side_t      side_o,
  output logic signed [31:0]  rem_o
);
  logic [4:0]  lz;
  logic [31:0] z;
  logic [6:0]  k;
  logic        inv;

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (operand_i[i]) lz = 5'(31 - i);
    end
    inv = (operand_i == 32'd0) || operand_i[31];
    z   = (operand_i << lz) << 1;
    k   = {1'b0, z[31:26]} + {6'd0, z[25]};
    rem_o = $signed(z - {k[5:0], 26'd0});
    side_o.inv = inv;
    side_o.lz  = lz;
    side_o.k   = k;
  end
endmodule

FILE: src/fpl_cubic.sv
`timescale 1ns / 1ps
// Cubic term magnitude pieces: floor(mag^2 / 2^31) times mag, registered.
module fpl_cubic (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [32:0] mag_i,
  input  logic [32:0] sq_i,
  output logic [65:0] cube_o
);
  logic [65:0] cube_q, cube_d;
  assign cube_d = 66'({33'd0, sq_i} * {33'd0, mag_i});
  always_ff @(posedge clk_i) begin
    if (en_i) cube_q <= cube_d;
  end
  assign cube_o = cube_q;
endmodule

FILE: src/fixed_point_natural_log.sv
`timescale 1ns / 1ps
// Natural logarithm of an s16.15 operand, result in s4.15 with an invalid
// flag for zero or negative operands (result then 0). Fully pipelined: one
// item per cycle, while the output is empty or taken, through eight register
// stages. The pipe advances as a whole whenever the output stage is empty or
// being taken, so a stall holds every stage and loses nothing. Stages: normalize
// and table index; reciprocal multiply; q squared; q^2 times |q|; cubic
// coefficient multiply; accumulate with the exponent term; round; output.
`include "fixed_point_natural_log_defines.svh"
module fixed_point_natural_log (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic signed [31:0] operand_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [19:0] log_value_o,
  output logic               invalid_o
);
  localparam int Stages = 8;

  logic [Stages-1:0] vld_q;
  logic              adv;

  // Advance the whole pipe unless the output holds an untaken item.
  assign adv     = !vld_q[Stages-1] || ready_i;
  assign ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Stages-2:0], valid_i};
    end
  end

  fpl_pkg::side_t side_n;
  logic signed [31:0] rem_n;
  fpl_pkg::side_t s1_q, s2_q, s3_q, s4_q, s5_q, s6_q, s7_q;

  fpl_norm u_norm (.operand_i(operand_i), .side_o(side_n), .rem_o(rem_n));

  // Stage 1: normalized remainder.
  logic signed [31:0] d1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= side_n;
      d1_q <= rem_n;
    end
  end

  // Stage 2: q = d + floor(d * recip / 2^16).
  logic signed [48:0] prod2;
  logic signed [32:0] q2_d, q2_q;
  assign prod2 = 49'(d1_q) * -$signed({1'b0, fpl_pkg::recip_mag(s1_q.k)});
  assign q2_d  = 33'(d1_q) + 33'(prod2 >>> 16);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q <= s1_q;
      q2_q <= q2_d;
    end
  end

  // Stage 3: |q| and floor(|q|^2 / 2^31).
  logic [32:0] mag3_d, mag3_q, sq3_q;
  logic [65:0] sqfull;
  logic signed [32:0] q3_q;
  assign mag3_d = q2_q[32] ? 33'(-q2_q) : 33'(q2_q);
  assign sqfull = 66'({33'd0, mag3_d} * {33'd0, mag3_d});
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_q   <= s2_q;
      q3_q   <= q2_q;
      mag3_q <= mag3_d;
      sq3_q  <= 33'(sqfull >> 31);
    end
  end

  // Stage 4: a = s * |q|.
  logic [65:0] a4;
  logic signed [32:0] q4_q;
  fpl_cubic u_cubic (.clk_i(clk_i), .en_i(adv), .mag_i(mag3_q), .sq_i(sq3_q),
                     .cube_o(a4));
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_q <= s3_q;
      q4_q <= q3_q;
    end
  end

  // Stage 5: coefficient times a, then floor by 2^62 with sign.
  logic [97:0] t5;
  logic [35:0] f5;
  logic        rem5;
  logic signed [36:0] term5;
  logic signed [33:0] q5_d, q5_q;
  assign t5    = 98'({32'd0, a4} * {66'd0, fpl_pkg::CubicCoef});
  assign f5    = 36'(t5 >> 62);
  assign rem5  = |t5[61:0];
  assign term5 = q4_q[32] ? -$signed({1'b0, f5} + {36'd0, rem5}) : $signed({1'b0, f5});
  assign q5_d  = 34'(37'(q4_q) + term5);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_q <= s4_q;
      q5_q <= q5_d;
    end
  end

  // Stage 6: accumulate table log, scaled q and exponent term (mod 2^32).
  logic signed [6:0]  e6;
  logic [31:0] acc6_d, acc6_q;
  assign e6     = $signed({2'b00, s5_q.lz}) - 7'sd16;
  assign acc6_d = fpl_pkg::ln_tab(s5_q.k) + 32'(q5_q >>> 5)
                - 32'($signed(e6) * $signed({1'b0, fpl_pkg::Ln2U527}));
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_q   <= s5_q;
      acc6_q <= acc6_d;
    end
  end

  // Stage 7: round to s4.15 and drop the bias.
  logic [19:0] res7_d, res7_q;
  assign res7_d = 20'(acc6_q[31:12]) + {19'd0, acc6_q[11]} - fpl_pkg::BiasS1615;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_q   <= s6_q;
      res7_q <= res7_d;
    end
  end

  // Stage 8: output register.
  logic [19:0] out_q;
  logic        inv_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= s7_q.inv ? 20'd0 : res7_q;
      inv_q <= s7_q.inv;
    end
  end

  assign valid_o     = vld_q[Stages-1];
  assign log_value_o = $signed(out_q);
  assign invalid_o   = inv_q;

  `FPL_ASSERT(a_stall_holds, clk_i, rst_ni, valid_o && !ready_i |=> valid_o && $stable(out_q))
  `FPL_ASSERT(a_inv_zero, clk_i, rst_ni, valid_o && invalid_o |-> log_value_o == 20'sd0)
  `FPL_ASSERT(a_ready_rule, clk_i, rst_ni, ready_o == (!valid_o || ready_i))
endmodule
